[rtl/core/lprt_pkg.sv]
package lprt_pkg;

  localparam int DATA_W = 120;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_RMIDX  = 3'd2;
  localparam logic [2:0] OP_RMIF   = 3'd3;
  localparam logic [2:0] OP_RMNET  = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;
  localparam logic [2:0] OP_DFLT   = 3'd6;
  localparam logic [2:0] OP_NOP    = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOROUTE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  localparam logic [5:0] HOST_PLEN = 6'd32;

  typedef struct packed {
    logic [31:0] cost;
    logic [3:0]  ifc;
    logic [31:0] gw;
    logic [5:0]  plen;
    logic [31:0] net;
  } route_t;

  function automatic logic [31:0] plen_mask(input logic [5:0] plen);
    logic [31:0] m;
    if (plen == 6'd0) begin
      m = 32'd0;
    end else if (plen >= HOST_PLEN) begin
      m = 32'hffffffff;
    end else begin
      m = 32'hffffffff << (HOST_PLEN - plen);
    end
    return m;
  endfunction

endpackage

[rtl/core/longest_prefix_route_table_top.sv]
// Append and op 7 go from idle through start to finish; read by index adds a read state.
// Lookup, default query and removals walk the table once through the single entry
// memory (a lookup ends early on a /32 hit); a filtered link-local multicast lookup
// and a remove by index out of range skip the walk. One request at a time: the next is
// taken the cycle after the result is registered, which an output stall can hold back.
// Reset clears the route count; the entry memory is not cleared.
module longest_prefix_route_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // address[31:0] prefix_len[37:32] gateway[69:38] iface[73:70]
  // use_iface_filter[74] route_cost[106:75] entry_index[112:107]
  input  logic [lprt_pkg::DATA_W-1:0]  s_tdata,
  // op[2:0]
  input  logic [2:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // out_network[31:0] out_prefix_len[37:32] out_gateway[69:38] out_iface[73:70]
  // out_cost[105:74] entry_count[112:106]
  output logic [lprt_pkg::DATA_W-1:0]  m_tdata,
  // status[1:0]
  output logic [1:0]                   m_tuser
);
  import lprt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (CW > 7) ? CW : 7;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]    state;
  logic [2:0]    req_op;
  logic [31:0]   req_addr;
  logic [5:0]    req_plen;
  logic [31:0]   req_gw;
  logic [3:0]    req_if;
  logic          req_filt;
  logic [31:0]   req_cost;
  logic [5:0]    req_idx;

  logic [CW-1:0] used;
  logic [CW-1:0] rd_ptr;
  logic [CW-1:0] wr_ptr;
  logic [CW-1:0] d_idx;
  logic          d_vld;

  logic [5:0]    best_len;
  logic [31:0]   best_cost;
  logic [1:0]    res_status;
  route_t        res_entry;

  route_t        mem [TABLE_DEPTH];
  route_t        mem_q;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  route_t        mem_wdata;

  route_t        ent;
  route_t        new_entry;
  route_t        start_entry;
  logic          lk_acc;
  logic          lk_stop;
  logic          df_acc;
  logic          kill;
  logic          is_rm;
  logic          issue;
  logic          rng_ok;
  logic          full;
  logic          mcast;
  logic [31:0]   eff_cost;
  logic [5:0]    in_plen;

  assign ent = mem_q;
  assign s_tready = (state == S_IDLE);
  assign in_plen = (s_tdata[37:32] > HOST_PLEN) ? HOST_PLEN : s_tdata[37:32];

  assign new_entry = '{cost: req_cost, ifc: req_if, gw: req_gw, plen: req_plen, net: req_addr};
  assign rng_ok = EW'(req_idx) < EW'(used);
  assign full = (used >= CW'(TABLE_DEPTH));
  assign mcast = req_filt && ((req_addr & 32'hffffff00) == 32'he0000000);
  assign is_rm = (req_op == OP_RMIDX) || (req_op == OP_RMIF) || (req_op == OP_RMNET);

  // link-local multicast with a filter answers directly on the requested interface
  always_comb begin
    start_entry = '0;
    if ((req_op == OP_LOOKUP) && mcast) begin
      start_entry = '{cost: 32'd0, ifc: req_if, gw: 32'd0, plen: HOST_PLEN, net: req_addr};
    end
  end

  // candidate evaluation on the entry just read
  assign eff_cost = (ent.plen > best_len) ? 32'hffffffff : best_cost;
  assign lk_acc = (((req_addr ^ ent.net) & plen_mask(ent.plen)) == 32'd0) &&
                  (!req_filt || (ent.ifc == req_if)) &&
                  (ent.plen >= best_len) && (ent.cost <= eff_cost);
  assign lk_stop = d_vld && (req_op == OP_LOOKUP) && lk_acc && (ent.plen == HOST_PLEN);
  assign df_acc = (ent.plen == 6'd0) && (ent.cost <= best_cost);

  always_comb begin
    case (req_op)
      OP_RMIDX: kill = (EW'(d_idx) == EW'(req_idx));
      OP_RMIF:  kill = (ent.ifc == req_if);
      OP_RMNET: kill = (ent.ifc == req_if) && (ent.plen != HOST_PLEN) &&
                       (ent.plen == req_plen) &&
                       (ent.net == (req_addr & plen_mask(req_plen)));
      default:  kill = 1'b0;
    endcase
  end

  assign issue = (state == S_RUN) && (rd_ptr < used);

  always_comb begin
    mem_re    = issue || ((state == S_START) && (req_op == OP_READ) && rng_ok);
    mem_raddr = (state == S_START) ? AW'(req_idx) : rd_ptr[AW-1:0];
    // compaction writes trail the read pointer, so no forwarding is needed
    mem_we    = ((state == S_START) && (req_op == OP_APPEND) && !full) ||
                ((state == S_RUN) && d_vld && is_rm && !kill);
    mem_waddr = (state == S_START) ? used[AW-1:0] : wr_ptr[AW-1:0];
    mem_wdata = (state == S_START) ? new_entry : ent;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used     <= '0;
      d_vld    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_op   <= s_tuser;
            req_addr <= s_tdata[31:0];
            req_plen <= in_plen;
            req_gw   <= s_tdata[69:38];
            req_if   <= s_tdata[73:70];
            req_filt <= s_tdata[74];
            req_cost <= s_tdata[106:75];
            req_idx  <= s_tdata[112:107];
            state    <= S_START;
          end
        end
        S_START: begin
          res_entry  <= start_entry;
          best_len   <= 6'd0;
          best_cost  <= 32'hffffffff;
          rd_ptr     <= '0;
          wr_ptr     <= '0;
          d_vld      <= 1'b0;
          case (req_op)
            OP_APPEND: begin
              state <= S_FIN;
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_OK;
                used       <= used + 1'b1;
              end
            end
            OP_LOOKUP: begin
              if (mcast) begin
                res_status <= ST_OK;
                state      <= S_FIN;
              end else begin
                res_status <= ST_NOROUTE;
                state      <= S_RUN;
              end
            end
            OP_RMIDX: begin
              if (rng_ok) begin
                res_status <= ST_OK;
                state      <= S_RUN;
              end else begin
                res_status <= ST_RANGE;
                state      <= S_FIN;
              end
            end
            OP_RMIF, OP_RMNET: begin
              res_status <= ST_OK;
              state      <= S_RUN;
            end
            OP_READ: begin
              if (rng_ok) begin
                res_status <= ST_OK;
                state      <= S_READ;
              end else begin
                res_status <= ST_RANGE;
                state      <= S_FIN;
              end
            end
            OP_DFLT: begin
              res_status <= ST_NOROUTE;
              state      <= S_RUN;
            end
            default: begin
              res_status <= ST_OK;
              state      <= S_FIN;
            end
          endcase
        end
        S_RUN: begin
          d_vld <= issue;
          d_idx <= rd_ptr;
          if (issue) begin
            rd_ptr <= rd_ptr + 1'b1;
          end
          if (d_vld) begin
            case (req_op)
              OP_LOOKUP: begin
                if (lk_acc) begin
                  best_len   <= ent.plen;
                  best_cost  <= ent.cost;
                  res_entry  <= ent;
                  res_status <= ST_OK;
                end
              end
              OP_DFLT: begin
                if (df_acc) begin
                  best_cost  <= ent.cost;
                  res_entry  <= ent;
                  res_status <= ST_OK;
                end
              end
              default: begin
                if (kill) begin
                  if (req_op == OP_RMIDX) begin
                    res_entry <= ent;
                  end
                end else begin
                  wr_ptr <= wr_ptr + 1'b1;
                end
              end
            endcase
          end
          if (lk_stop) begin
            state <= S_FIN;
          end else if (!d_vld && !issue) begin
            if (is_rm) begin
              used <= wr_ptr;
            end
            state <= S_FIN;
          end
        end
        S_READ: begin
          res_entry <= ent;
          state     <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {7'd0, 7'(used), res_entry.cost, res_entry.ifc,
                         res_entry.gw, res_entry.plen, res_entry.net};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(TABLE_DEPTH))
    else $error("route count beyond table depth");

  a_wr_trails: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && d_vld) |-> wr_ptr <= d_idx)
    else $error("compaction write ahead of read");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_FIN)
    else $error("result issued outside finish");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (state == S_START && req_op == OP_APPEND && full) |=> res_status == ST_FULL)
    else $error("append to full table not flagged");

endmodule

[tb/lprt_checker.sv]
`timescale 1ns / 1ps

module lprt_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [lprt_pkg::DATA_W-1:0] s_tdata,
  input  logic [2:0]                  s_tuser,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [lprt_pkg::DATA_W-1:0] m_tdata,
  input  logic [1:0]                  m_tuser,
  output int                          fail_count,
  output int                          pending
);
  import lprt_pkg::*;

  localparam int DEPTH = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  count;
    route_t      rt;
  } route_reply_t;

  route_t       routes [DEPTH];
  int           route_count;
  route_reply_t reply_queue [$];

  assign pending = reply_queue.size();

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    if (len == 0) return 32'd0;
    if (len >= 32) return 32'hffffffff;
    return 32'hffffffff << (32 - len);
  endfunction

  function automatic void drop_route(input int k);
    for (int m = k; m + 1 < route_count; m++) routes[m] = routes[m + 1];
    route_count--;
  endfunction

  function automatic route_reply_t apply_request(input logic [2:0] op,
                                                 input logic [119:0] d);
    route_reply_t r;
    logic [31:0] addr, gw, cost, best_cost, target;
    logic [5:0]  plen, best_len, idx;
    logic [3:0]  ifc;
    logic        filt, found;
    int          sel, k;
    addr = d[31:0]; plen = d[37:32]; gw = d[69:38]; ifc = d[73:70];
    filt = d[74]; cost = d[106:75]; idx = d[112:107];
    if (plen > 32) plen = 32;
    r = '0;
    r.status = ST_OK;
    sel = 0;
    found = 0;
    case (op)
      OP_APPEND: begin
        if (route_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          routes[route_count] = '{cost: cost, ifc: ifc, gw: gw, plen: plen, net: addr};
          route_count++;
        end
      end
      OP_LOOKUP: begin
        if (filt && addr[31:8] == 24'he00000) begin
          r.rt = '{cost: 32'd0, ifc: ifc, gw: 32'd0, plen: HOST_PLEN, net: addr};
        end else begin
          best_len = 0;
          best_cost = 32'hffffffff;
          for (k = 0; k < route_count; k++) begin
            if ((addr & prefix_mask(routes[k].plen)) !=
                (routes[k].net & prefix_mask(routes[k].plen))) continue;
            if (filt && routes[k].ifc != ifc) continue;
            if (routes[k].plen < best_len) continue;
            if (routes[k].plen > best_len) best_cost = 32'hffffffff;
            best_len = routes[k].plen;
            if (routes[k].cost > best_cost) continue;
            best_cost = routes[k].cost;
            found = 1;
            sel = k;
            if (routes[k].plen == 32) break;
          end
          if (found) r.rt = routes[sel];
          else r.status = ST_NOROUTE;
        end
      end
      OP_RMIDX: begin
        if (idx >= route_count) begin
          r.status = ST_RANGE;
        end else begin
          r.rt = routes[idx];
          drop_route(idx);
        end
      end
      OP_RMIF: begin
        k = 0;
        while (k < route_count)
          if (routes[k].ifc == ifc) drop_route(k);
          else k++;
      end
      OP_RMNET: begin
        target = addr & prefix_mask(plen);
        k = 0;
        while (k < route_count)
          if (routes[k].ifc == ifc && routes[k].plen != 32 && routes[k].plen == plen &&
              routes[k].net == target) drop_route(k);
          else k++;
      end
      OP_READ: begin
        if (idx >= route_count) r.status = ST_RANGE;
        else r.rt = routes[idx];
      end
      OP_DFLT: begin
        best_cost = 32'hffffffff;
        for (k = 0; k < route_count; k++) begin
          if (routes[k].plen != 0) continue;
          if (routes[k].cost > best_cost) continue;
          best_cost = routes[k].cost;
          sel = k;
          found = 1;
        end
        if (found) r.rt = routes[sel];
        else r.status = ST_NOROUTE;
      end
      default: ;
    endcase
    r.count = route_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    route_reply_t e;
    if (rst) begin
      route_count = 0;
      reply_queue.delete();
      fail_count = 0;
    end else begin
      if (s_tvalid && s_tready) reply_queue = {reply_queue, apply_request(s_tuser, s_tdata)};
      if (m_tvalid && m_tready) begin
        if (reply_queue.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
        end else begin
          e = reply_queue.pop_front();
          if (m_tuser != e.status) report_mismatch("status", m_tuser, e.status);
          if (m_tdata[31:0] != e.rt.net) report_mismatch("network", m_tdata[31:0], e.rt.net);
          if (m_tdata[37:32] != e.rt.plen) report_mismatch("prefix", m_tdata[37:32], e.rt.plen);
          if (m_tdata[69:38] != e.rt.gw) report_mismatch("gateway", m_tdata[69:38], e.rt.gw);
          if (m_tdata[73:70] != e.rt.ifc) report_mismatch("iface", m_tdata[73:70], e.rt.ifc);
          if (m_tdata[105:74] != e.rt.cost) report_mismatch("cost", m_tdata[105:74], e.rt.cost);
          if (m_tdata[112:106] != e.count)
            report_mismatch("count", m_tdata[112:106], e.count);
        end
      end
    end
  end
endmodule

[tb/tb_longest_prefix_route_table_top.sv]
`timescale 1ns / 1ps

module tb_longest_prefix_route_table_top;
  import lprt_pkg::*;

  logic                clk = 0;
  logic                rst = 1;
  logic                s_tvalid = 0;
  logic                s_tready;
  logic [DATA_W-1:0]   s_tdata = '0;
  logic [2:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 0;
  logic [DATA_W-1:0]   m_tdata;
  logic [1:0]          m_tuser;
  int                  fail_count;
  int                  pending;
  int                  hold_cycles = 0;
  logic                hold_now = 0;
  logic                hold_req = 0;
  int                  live_routes = 0;
  logic [31:0]         known_nets [$];

  always #5 clk = ~clk;

  longest_prefix_route_table_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  lprt_checker route_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (hold_now) begin
      m_tready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 0;
    end else if (m_tready && m_tvalid) begin
      hold_cycles <= ($urandom_range(0, 1) == 0) ? 0 : gap_len();
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  // long hold-off, counted in cycles
  initial begin
    @(posedge clk iff hold_req);
    hold_now <= 1;
    repeat (300) @(posedge clk);
    hold_now <= 0;
  end

  task automatic send_request(input logic [2:0] op, input logic [31:0] addr,
                              input logic [5:0] plen, input logic [31:0] gw,
                              input logic [3:0] ifc, input logic filt,
                              input logic [31:0] cost, input logic [5:0] idx,
                              input logic quick);
    int g;
    g = quick ? 0 : gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {7'd0, idx, cost, filt, ifc, gw, plen, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic random_request(input logic quick);
    logic [2:0]  op;
    logic [31:0] addr;
    logic [5:0]  plen;
    logic [3:0]  ifc;
    int          r;
    r = $urandom_range(0, 99);
    ifc = 4'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) ifc = 4'($urandom);
    plen = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
                                         6'(8 * $urandom_range(0, 4));
    addr = $urandom;
    if (known_nets.size() > 0 && $urandom_range(0, 2) != 0)
      addr = known_nets[$urandom_range(0, known_nets.size() - 1)] ^ ($urandom & 32'hff);
    if (r < 35 && live_routes < 60) op = OP_APPEND;
    else if (r < 65) op = OP_LOOKUP;
    else if (r < 72) op = OP_RMIDX;
    else if (r < 75) op = OP_RMIF;
    else if (r < 82) op = OP_RMNET;
    else if (r < 90) op = OP_READ;
    else if (r < 96) op = OP_DFLT;
    else if (r < 98) op = OP_NOP;
    else op = OP_APPEND;
    if ($urandom_range(0, 30) == 0) addr = 32'he00000ff & {24'hffffff, 8'($urandom)};
    if (op == OP_APPEND) begin
      known_nets = {known_nets, addr};
      if (known_nets.size() > 40) void'(known_nets.pop_front());
    end
    send_request(op, addr, plen, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom, ifc,
                 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 5)) : $urandom,
                 ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 20)),
                 quick);
    // track occupancy loosely; removals shrink it back
    if (op == OP_APPEND && live_routes < 64) live_routes++;
    if (op == OP_RMIF || op == OP_RMNET) live_routes = live_routes / 2;
    if (op == OP_RMIDX && live_routes > 0) live_routes--;
  endtask

  task automatic wait_drained();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed
    send_request(OP_LOOKUP, 32'h0a000001, 6'd8, 0, 0, 0, 0, 0, 0);
    send_request(OP_DFLT, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 0, 0, 6'd0, 0);
    send_request(OP_RMIDX, 0, 0, 0, 0, 0, 0, 6'd63, 0);
    send_request(OP_APPEND, 32'h00000000, 6'd0, 32'hc0a80001, 4'd1, 0, 32'd10, 0, 0);
    send_request(OP_APPEND, 32'hffffffff, 6'd0, 32'hffffffff, 4'd15, 1, 32'd10, 6'd63, 0);
    send_request(OP_APPEND, 32'h0a0000ff, 6'd8, 32'd0, 4'd2, 0, 32'hffffffff, 0, 0);
    send_request(OP_APPEND, 32'h0a0b0000, 6'd16, 32'h1, 4'd3, 0, 32'd5, 0, 0);
    send_request(OP_APPEND, 32'h0a0b0c0d, 6'd63, 32'h2, 4'd3, 0, 32'd0, 0, 0);
    send_request(OP_APPEND, 32'h0a0b0000, 6'd16, 32'h3, 4'd2, 0, 32'd5, 0, 0);
    send_request(OP_LOOKUP, 32'h0a0b0c0d, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_LOOKUP, 32'h0a0b0c0e, 0, 0, 4'd3, 1, 0, 0, 0);
    send_request(OP_LOOKUP, 32'h0a010101, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_LOOKUP, 32'he0000005, 0, 0, 4'd9, 1, 0, 0, 0);
    send_request(OP_LOOKUP, 32'he0000005, 0, 0, 4'd9, 0, 0, 0, 0);
    send_request(OP_LOOKUP, 32'h0b000000, 0, 0, 4'd7, 1, 0, 0, 0);
    send_request(OP_DFLT, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 0, 0, 6'd4, 0);
    send_request(OP_RMNET, 32'h0a0bffff, 6'd16, 0, 4'd2, 0, 0, 0, 0);
    send_request(OP_RMNET, 32'h0a0b0c0d, 6'd32, 0, 4'd3, 0, 0, 0, 0);
    send_request(OP_RMIDX, 0, 0, 0, 0, 0, 0, 6'd1, 0);
    send_request(OP_NOP, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_RMIF, 0, 0, 0, 4'd3, 0, 0, 0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 0, 0, 6'd2, 0);
    // fill to full, overflow, then empty
    for (int i = 0; i < 66; i++)
      send_request(OP_APPEND, $urandom, 6'($urandom_range(0, 32)), $urandom, 4'd5, 0,
                   $urandom, 0, 1);
    send_request(OP_READ, 0, 0, 0, 0, 0, 0, 6'd63, 0);
    send_request(OP_RMIF, 0, 0, 0, 4'd5, 0, 0, 0, 0);
    send_request(OP_RMIF, 0, 0, 0, 4'd1, 0, 0, 0, 0);
    send_request(OP_RMIF, 0, 0, 0, 4'd15, 0, 0, 0, 0);
    send_request(OP_RMIF, 0, 0, 0, 4'd0, 0, 0, 0, 0);
    send_request(OP_RMIF, 0, 0, 0, 4'd2, 0, 0, 0, 0);
    wait_drained();
    live_routes = 0;
    // long receiver hold-off while the sender keeps going
    hold_req <= 1;
    for (int i = 0; i < 20; i++) random_request(1);
    for (int i = 0; i < 300; i++) random_request(0);
    wait_drained();
    for (int i = 0; i < 300; i++) random_request($urandom_range(0, 3) == 0);
    wait_drained();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

[sim.f]
rtl/core/lprt_pkg.sv
rtl/core/longest_prefix_route_table_top.sv
tb/lprt_checker.sv
tb/tb_longest_prefix_route_table_top.sv
